[hw/rtl/aes128_block_encrypt_core_defines.svh]
// aes128_block_encrypt_core_defines.svh: assertion macros for the aes-128 encrypt core
// included by the rtl files that carry assertions; no other dependencies
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// when ante holds on a clock edge, cons must hold on the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// expr must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

[hw/rtl/aes128enc_pkg.sv]
// aes128enc_pkg: constants, s-box table and round functions for the aes-128 encrypt core
// no dependencies; used by aes128enc_round and aes128_block_encrypt_core
`timescale 1ns / 1ps

package aes128enc_pkg;

    localparam int NR       = 10;
    localparam int BLOCK_W  = 128;
    localparam int HALF_W   = 64;
    localparam int LATENCY  = NR + 1;

    localparam logic IDX_KEY_UPPER = 1'b0;
    localparam logic IDX_KEY_LOWER = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [7:0]         byte_t;

    localparam byte_t RCON [NR] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t get_byte(block_t b, int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic byte_t xtime(byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes then shiftrows; byte index is 4*column + row
    function automatic block_t sub_shift(block_t s);
        block_t t;
        int c;
        int r;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(block_t s);
        block_t t;
        byte_t a0;
        byte_t a1;
        byte_t a2;
        byte_t a3;
        byte_t all;
        int c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // one step of the key schedule: rotword, subword, rcon, then the word chain
    function automatic block_t next_key(block_t rk, byte_t rc);
        logic [31:0] temp;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        temp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0   = rk[127:96] ^ temp;
        w1   = rk[95:64] ^ w0;
        w2   = rk[63:32] ^ w1;
        w3   = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[hw/rtl/aes128_block_encrypt_core.sv]
// aes128_block_encrypt_core: aes-128 encryption as a chain of ten round cells
// depends on aes128enc_pkg, aes128enc_round and aes128_block_encrypt_core_defines.svh
//
//  channel   handshake        payload                       direction
//  input     start / busy     plain_upper, plain_lower      in
//  result    done             cipher_upper, cipher_lower    out
//  config    wr_en            wr_index, wr_data             in
//
// one block is taken per cycle, busy stays low; each block passes through a register for the
// initial key add and then through each round cell in turn, each cell holding a round
// and the round key that travels with its block
// reset clears the key registers and the valid bits of the chain
// done is high for one cycle per result; the receiver cannot stall the chain
`timescale 1ns / 1ps
`include "aes128_block_encrypt_core_defines.svh"

module aes128_block_encrypt_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [aes128enc_pkg::HALF_W-1:0]  plain_upper,
    input  logic [aes128enc_pkg::HALF_W-1:0]  plain_lower,
    output logic                              done,
    output logic [aes128enc_pkg::HALF_W-1:0]  cipher_upper,
    output logic [aes128enc_pkg::HALF_W-1:0]  cipher_lower,
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [aes128enc_pkg::HALF_W-1:0]  wr_data
);

    localparam int NR = aes128enc_pkg::NR;

    logic [aes128enc_pkg::HALF_W-1:0] key_upper_reg;
    logic [aes128enc_pkg::HALF_W-1:0] key_lower_reg;
    logic                             valid0_reg;
    aes128enc_pkg::block_t            state0_reg;
    aes128enc_pkg::block_t            rk0_reg;
    logic                             accept;

    logic                  valid_chain [NR+1];
    aes128enc_pkg::block_t state_chain [NR+1];
    aes128enc_pkg::block_t rk_chain    [NR+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            valid0_reg    <= 1'b0;
        end
        else
        begin
            valid0_reg <= accept;
            if (wr_en)
            begin
                case (wr_index)
                    aes128enc_pkg::IDX_KEY_UPPER: key_upper_reg <= wr_data;
                    aes128enc_pkg::IDX_KEY_LOWER: key_lower_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    // initial add round key
    always_ff @(posedge clk)
    begin
        state0_reg <= {plain_upper, plain_lower} ^ {key_upper_reg, key_lower_reg};
        rk0_reg    <= {key_upper_reg, key_lower_reg};
    end

    assign valid_chain[0] = valid0_reg;
    assign state_chain[0] = state0_reg;
    assign rk_chain[0]    = rk0_reg;

    for (genvar g = 0; g < NR; g++)
    begin : g_round
        aes128enc_round #(
            .RCON_VAL (aes128enc_pkg::RCON[g]),
            .LAST     (g == NR - 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[g]),
            .state_in  (state_chain[g]),
            .rk_in     (rk_chain[g]),
            .valid_out (valid_chain[g+1]),
            .state_out (state_chain[g+1]),
            .rk_out    (rk_chain[g+1])
        );
    end

    assign done         = valid_chain[NR];
    assign cipher_upper = state_chain[NR][aes128enc_pkg::BLOCK_W-1:aes128enc_pkg::HALF_W];
    assign cipher_lower = state_chain[NR][aes128enc_pkg::HALF_W-1:0];

    // every result traces back to a transaction taken a fixed latency earlier
    `ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(accept, aes128enc_pkg::LATENCY))

endmodule

[hw/rtl/aes128enc_round.sv]
// aes128enc_round: one round cell of the encrypt chain, derives its own round key
// depends on aes128enc_pkg and aes128_block_encrypt_core_defines.svh
`timescale 1ns / 1ps
`include "aes128_block_encrypt_core_defines.svh"

module aes128enc_round #(
    parameter logic [7:0] RCON_VAL = aes128enc_pkg::RCON[0],
    parameter bit         LAST     = 1'b0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  aes128enc_pkg::block_t   state_in,
    input  aes128enc_pkg::block_t   rk_in,
    output logic                    valid_out,
    output aes128enc_pkg::block_t   state_out,
    output aes128enc_pkg::block_t   rk_out
);

    logic                  valid_reg;
    aes128enc_pkg::block_t state_reg;
    aes128enc_pkg::block_t state_next;
    aes128enc_pkg::block_t rk_reg;
    aes128enc_pkg::block_t rk_next;
    aes128enc_pkg::block_t shifted;

    always_comb
    begin
        rk_next = aes128enc_pkg::next_key(rk_in, RCON_VAL);
        shifted = aes128enc_pkg::sub_shift(state_in);
        if (LAST)
        begin
            state_next = shifted ^ rk_next;
        end
        else
        begin
            state_next = aes128enc_pkg::mix_columns(shifted) ^ rk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign rk_out    = rk_reg;

    `ASSERT_IMPL(a_valid_from_prev, clk, rst_n, valid_reg, $past(valid_in))
    // last key word is the xor of the new third word and the old last word
    `ASSERT_IMPL(a_key_chain, clk, rst_n, valid_reg, rk_reg[31:0] == (rk_reg[63:32] ^ $past(rk_in[31:0])))

endmodule
